### hw/rtl/hsa_pkg.sv
// Shared widths, field layout and operation/status codes of the handle slot allocator.
package hsa_pkg;

	localparam int ENTRIES_DEF    = 16;
	localparam int VALUE_BITS_DEF = 32;

	localparam int OP_W     = 2;
	localparam int VALUE_W  = 32;
	localparam int SLOT_W   = 4;
	localparam int STATUS_W = 2;

	// request word: op, value_in, slot_in from the lowest bit up
	localparam int IN_VALUE_LSB = OP_W;
	localparam int IN_SLOT_LSB  = OP_W + VALUE_W;
	localparam int IN_FIELDS_W  = OP_W + VALUE_W + SLOT_W;
	localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;

	// response word: slot_out, value_out, status from the lowest bit up
	localparam int OUT_FIELDS_W = SLOT_W + VALUE_W + STATUS_W;
	localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

	typedef logic [OP_W-1:0]     op_t;
	typedef logic [STATUS_W-1:0] status_t;

	localparam op_t OP_ALLOC   = 2'd0;
	localparam op_t OP_RELEASE = 2'd1;
	localparam op_t OP_LOOKUP  = 2'd2;

	localparam status_t ST_OK       = 2'd0;
	localparam status_t ST_FULL     = 2'd1;
	localparam status_t ST_OVERFLOW = 2'd2;

endpackage

### hw/rtl/handle_slot_allocator.sv
// Handle slot allocator: free-list handle table with a stream request and response channel.
//
// Requests come in on the s_ group, responses leave on the m_ group, one response per request.
// op 0 allocates: value_in is stored in the head free slot, whose number comes back in
// slot_out; status 1 when no slot is free. op 1 releases slot_in onto the free list;
// status 2 when every slot is already free. op 2 looks up slot_in and returns its word.
// A request word passes through the input stage and the output register to its response word.
// Throughput is one word per clock unless a stall holds it: the slot store's single read port is
// addressed from the head the previous word leaves, with that word's pending write forwarded.
// After reset the slot store is initialized by a sweep over all ENTRIES slots, one slot a cycle;
// s_tready stays low until it is done. Head returns to slot 0 and all slots are free.
// When the receiver stalls, the response stays in the output register and the word behind it
// waits in the input stage; outside the init sweep, s_tready drops only once both are full.
module handle_slot_allocator
	import hsa_pkg::*;
#(
	parameter int ENTRIES    = ENTRIES_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // op[1:0], value_in[33:2], slot_in[37:34]
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata    // slot_out[3:0], value_out[35:4], status[37:36]
);

	localparam int IW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);
	localparam int MW = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
	localparam int RW = (MW > IW + 1) ? MW : IW + 1;
	// floor(2^MW / ENTRIES): quotient estimate is at most one short
	localparam logic [MW-1:0] RECIP = MW'((64'd1 << MW) / 64'(ENTRIES));
	localparam logic [CW-1:0] FULL_CNT = CW'(ENTRIES);

	// input unpack
	op_t                 op_in;
	logic [VALUE_W-1:0]  val_in;
	logic [SLOT_W-1:0]   slot_in;
	logic [2*MW-1:0]     qprod;
	logic [MW-1:0]       qest_in;
	logic [IW-1:0]       rd_addr;
	logic                accept;
	logic                advance;
	logic                ram_busy;

	// stage 1
	logic                  valid_s1;
	op_t                   op_s1;
	logic [VALUE_BITS-1:0] val_s1;
	logic [SLOT_W-1:0]     slot_s1;
	logic [MW-1:0]         qest_s1;
	logic                  fwd_s1;
	logic [VALUE_BITS-1:0] fwd_val_s1;
	logic [IW-1:0]         fwd_lnk_s1;

	logic [VALUE_BITS-1:0] rd_val;
	logic [IW-1:0]         rd_lnk;

	// free list state
	logic [IW-1:0] head_q;
	logic [CW-1:0] count_q;

	// stage 1 resolution
	logic [VALUE_BITS-1:0] word_s1;
	logic [IW-1:0]         link_s1;
	logic [RW-1:0]         rem;
	logic [RW-1:0]         rem_fix;
	logic [IW-1:0]         alloc_lnk;
	logic [VALUE_BITS-1:0] rel_word;
	logic                  slot_ok;
	logic                  wr_req;
	logic                  wr_en;
	logic [IW-1:0]         wr_addr;
	logic [VALUE_BITS-1:0] wr_val;
	logic [IW-1:0]         wr_lnk;
	logic [IW-1:0]         head_d;
	logic [CW-1:0]         count_d;
	logic [SLOT_W-1:0]     res_slot;
	logic [VALUE_W-1:0]    res_val;
	status_t               res_status;

	// output register
	logic                   m_tvalid_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;

	assign op_in   = s_tdata[OP_W-1:0];
	assign val_in  = s_tdata[IN_VALUE_LSB +: VALUE_W];
	assign slot_in = s_tdata[IN_SLOT_LSB +: SLOT_W];

	assign advance  = valid_s1 && (!m_tvalid_q || m_tready);
	assign s_tready = !ram_busy && (!valid_s1 || advance);
	assign accept   = s_tvalid && s_tready;

	// first half of value mod ENTRIES, finished in stage 1
	assign qprod   = {{MW{1'b0}}, MW'(val_in)} * {{MW{1'b0}}, RECIP};
	assign qest_in = qprod[2*MW-1:MW];

	// allocate reads the head left by the word ahead
	assign rd_addr = (op_in == OP_ALLOC) ? head_d : IW'(slot_in);
	assign wr_en   = wr_req && advance;

	hsa_slot_ram #(
		.ENTRIES    (ENTRIES),
		.VALUE_BITS (VALUE_BITS)
	) u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.busy    (ram_busy),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_val  (wr_val),
		.wr_lnk  (wr_lnk),
		.rd_en   (accept),
		.rd_addr (rd_addr),
		.rd_val  (rd_val),
		.rd_lnk  (rd_lnk)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1      <= op_in;
			val_s1     <= VALUE_BITS'(val_in);
			slot_s1    <= slot_in;
			qest_s1    <= qest_in;
			// write of the word ahead lands on the slot being read
			fwd_s1     <= wr_en && (wr_addr == rd_addr);
			fwd_val_s1 <= wr_val;
			fwd_lnk_s1 <= wr_lnk;
		end
	end

	always_comb begin
		word_s1   = fwd_s1 ? fwd_val_s1 : rd_val;
		link_s1   = fwd_s1 ? fwd_lnk_s1 : rd_lnk;
		rem       = RW'(MW'(val_s1)) - RW'(RW'(qest_s1) * RW'(ENTRIES));
		rem_fix   = (rem >= RW'(ENTRIES)) ? rem - RW'(ENTRIES) : rem;
		alloc_lnk = IW'(rem_fix);
		rel_word  = VALUE_BITS'(head_q);
		slot_ok   = 32'(slot_s1) < 32'(ENTRIES);

		wr_req     = 1'b0;
		wr_addr    = head_q;
		wr_val     = val_s1;
		wr_lnk     = alloc_lnk;
		head_d     = head_q;
		count_d    = count_q;
		res_slot   = slot_s1;
		res_val    = '0;
		res_status = ST_OK;

		if (valid_s1) begin
			case (op_s1)
				OP_ALLOC: begin
					if (count_q == '0) begin
						res_status = ST_FULL;
						res_slot   = '0;
					end else begin
						wr_req   = 1'b1;
						head_d   = link_s1;
						count_d  = count_q - CW'(1);
						res_slot = SLOT_W'(head_q);
					end
				end
				OP_RELEASE: begin
					if (count_q == FULL_CNT) begin
						res_status = ST_OVERFLOW;
					end else if (slot_ok) begin
						wr_req  = 1'b1;
						wr_addr = IW'(slot_s1);
						wr_val  = rel_word;
						// stored head is below ENTRIES, so it is its own residue
						wr_lnk  = IW'(rel_word);
						head_d  = IW'(slot_s1);
						count_d = count_q + CW'(1);
					end
				end
				OP_LOOKUP: begin
					if (slot_ok) begin
						res_val = VALUE_W'(word_s1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= FULL_CNT;
		end else if (advance) begin
			head_q  <= head_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (advance) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			m_tdata_q <= {{OUT_PAD_W{1'b0}}, res_status, res_val, res_slot};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

### hw/rtl/hsa_slot_ram.sv
// Slot store: value words plus link residues, one write and one registered read port, init sweep.
module hsa_slot_ram #(
	parameter int ENTRIES    = 16,
	parameter int VALUE_BITS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	output logic                        busy,
	input  logic                        wr_en,
	input  logic [$clog2(ENTRIES)-1:0]  wr_addr,
	input  logic [VALUE_BITS-1:0]       wr_val,
	input  logic [$clog2(ENTRIES)-1:0]  wr_lnk,
	input  logic                        rd_en,
	input  logic [$clog2(ENTRIES)-1:0]  rd_addr,
	output logic [VALUE_BITS-1:0]       rd_val,
	output logic [$clog2(ENTRIES)-1:0]  rd_lnk
);

	localparam int IW = $clog2(ENTRIES);

	logic [VALUE_BITS-1:0] val_mem [ENTRIES];
	// link residue (word mod ENTRIES) kept beside each word
	logic [IW-1:0]         lnk_mem [ENTRIES];

	logic          clr_busy_q;
	logic [IW-1:0] clr_idx_q;
	logic [IW:0]   clr_cnt;
	logic [VALUE_BITS-1:0] clr_val;
	logic [IW:0]   clr_m;
	logic [IW-1:0] clr_lnk;

	assign busy = clr_busy_q;

	// init chain: slot i holds i+1 cut to the word width and links to that word mod ENTRIES
	always_comb begin
		clr_cnt = {1'b0, clr_idx_q} + (IW+1)'(1);
		clr_val = VALUE_BITS'(clr_cnt);
		clr_m   = (IW+1)'(clr_val);
		clr_lnk = (clr_m == (IW+1)'(ENTRIES)) ? '0 : IW'(clr_m);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clr_busy_q) begin
			clr_idx_q <= clr_idx_q + IW'(1);
			if (clr_idx_q == IW'(ENTRIES - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			val_mem[clr_idx_q] <= clr_val;
			lnk_mem[clr_idx_q] <= clr_lnk;
		end else if (wr_en) begin
			val_mem[wr_addr] <= wr_val;
			lnk_mem[wr_addr] <= wr_lnk;
		end
		if (rd_en) begin
			rd_val <= val_mem[rd_addr];
			rd_lnk <= lnk_mem[rd_addr];
		end
	end

endmodule

### tb/handle_slot_allocator_tb.sv
// Self-checking testbench for the handle slot allocator: directed table, then random traffic.
`timescale 1ns / 1ps

module handle_slot_allocator_tb;
	import hsa_pkg::*;

	localparam int  ENTRIES = ENTRIES_DEF;
	localparam op_t OP_NONE = 2'd3;    // unused code, must act as a no-op

	typedef struct packed {
		logic [SLOT_W-1:0]  slot;
		logic [VALUE_W-1:0] value;
		status_t            status;
	} hsa_resp_t;

	typedef struct packed {
		op_t                op;
		logic [VALUE_W-1:0] value;
		logic [SLOT_W-1:0]  slot;
		logic               fixed;     // want is typed in, not predicted
		hsa_resp_t          want;
	} dir_row_t;

	localparam hsa_resp_t NO_WANT = '0;

	logic                   clk      = 1'b0;
	logic                   arst_n   = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata  = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;

	// predictor state
	logic [VALUE_BITS_DEF-1:0] slot_words [ENTRIES];
	int unsigned               head_slot;
	int unsigned               free_total;

	hsa_resp_t   want_q [$];
	logic [3:0]  held_q [$];     // slots the stimulus believes are allocated
	bit          steady   = 1'b0;
	int unsigned errors   = 0;
	int unsigned checked  = 0;
	int unsigned n_alloc  = 0;
	int unsigned n_rel    = 0;
	int unsigned n_look   = 0;
	int unsigned n_full   = 0;
	int unsigned n_ovf    = 0;

	dir_row_t dir_rows [] = '{
		'{OP_LOOKUP,  32'h0000_0000, 4'd0,  1'b1, '{4'd0,  32'd1,  ST_OK}},
		'{OP_LOOKUP,  32'h0000_0000, 4'd15, 1'b1, '{4'd15, 32'd16, ST_OK}},
		'{OP_RELEASE, 32'h0000_0000, 4'd9,  1'b1, '{4'd9,  32'd0,  ST_OVERFLOW}},
		'{OP_NONE,    32'hFFFF_FFFF, 4'd15, 1'b1, '{4'd15, 32'd0,  ST_OK}},
		'{OP_ALLOC,   32'hFFFF_FFFF, 4'd0,  1'b0, NO_WANT},
		'{OP_ALLOC,   32'h0000_0000, 4'd15, 1'b0, NO_WANT},
		'{OP_ALLOC,   32'h0000_0001, 4'd0,  1'b0, NO_WANT},
		'{OP_ALLOC,   32'h8000_0000, 4'd0,  1'b0, NO_WANT},
		'{OP_ALLOC,   32'h7FFF_FFFF, 4'd0,  1'b0, NO_WANT},
		'{OP_ALLOC,   32'hA5A5_A5A5, 4'd0,  1'b0, NO_WANT},
		'{OP_ALLOC,   32'h5A5A_5A5A, 4'd0,  1'b0, NO_WANT},
		'{OP_ALLOC,   32'h0000_000F, 4'd0,  1'b0, NO_WANT},
		'{OP_ALLOC,   32'h0000_0010, 4'd0,  1'b0, NO_WANT},
		'{OP_ALLOC,   32'h1234_5678, 4'd0,  1'b0, NO_WANT},
		'{OP_ALLOC,   32'hCAFE_F00D, 4'd0,  1'b0, NO_WANT},
		'{OP_ALLOC,   32'h0F0F_0F0F, 4'd0,  1'b0, NO_WANT},
		'{OP_ALLOC,   32'hF0F0_F0F0, 4'd0,  1'b0, NO_WANT},
		'{OP_ALLOC,   32'h0000_FFFF, 4'd0,  1'b0, NO_WANT},
		'{OP_ALLOC,   32'hFFFF_0000, 4'd0,  1'b0, NO_WANT},
		'{OP_ALLOC,   32'h3333_CCCC, 4'd0,  1'b0, NO_WANT},
		// table is full now
		'{OP_ALLOC,   32'hDEAD_BEEF, 4'd7,  1'b1, '{4'd0,  32'd0,  ST_FULL}},
		'{OP_LOOKUP,  32'h0000_0000, 4'd0,  1'b0, NO_WANT},
		// double release of slot 5, then two allocs both land on it;
		// the second follows a user word as link (taken mod ENTRIES)
		'{OP_RELEASE, 32'h0000_0000, 4'd5,  1'b0, NO_WANT},
		'{OP_RELEASE, 32'h0000_0000, 4'd5,  1'b0, NO_WANT},
		'{OP_ALLOC,   32'hFFFF_FFF3, 4'd0,  1'b0, NO_WANT},
		'{OP_ALLOC,   32'h0000_0012, 4'd0,  1'b0, NO_WANT},
		'{OP_LOOKUP,  32'h0000_0000, 4'd3,  1'b0, NO_WANT}
	};

	handle_slot_allocator dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	function automatic void table_reset();
		for (int i = 0; i < ENTRIES; i++)
			slot_words[i] = VALUE_BITS_DEF'(i + 1);
		head_slot  = 0;
		free_total = ENTRIES;
	endfunction

	// expected response of one request word; updates the predicted table
	function automatic hsa_resp_t table_step(op_t op, logic [VALUE_W-1:0] val,
	                                         logic [SLOT_W-1:0] slot);
		hsa_resp_t                 r;
		int unsigned               h;
		logic [VALUE_BITS_DEF-1:0] link;
		r.slot   = slot;
		r.value  = '0;
		r.status = ST_OK;
		case (op)
			OP_ALLOC: begin
				if (free_total == 0) begin
					r.status = ST_FULL;
					r.slot   = '0;
				end else begin
					h             = head_slot % ENTRIES;
					link          = slot_words[h];
					slot_words[h] = val;
					head_slot     = link % ENTRIES;
					free_total--;
					r.slot        = SLOT_W'(h);
				end
			end
			OP_RELEASE: begin
				if (free_total >= ENTRIES) begin
					r.status = ST_OVERFLOW;
				end else if (slot < ENTRIES) begin
					slot_words[slot] = VALUE_BITS_DEF'(head_slot);
					head_slot        = 32'(slot);
					free_total++;
				end
			end
			OP_LOOKUP: begin
				if (slot < ENTRIES)
					r.value = VALUE_W'(slot_words[slot]);
			end
			default: ;
		endcase
		return r;
	endfunction

	// present one word, wait for the handshake, then queue what must come back
	task automatic send_word(op_t op, logic [VALUE_W-1:0] val, logic [SLOT_W-1:0] slot,
	                         logic fixed, hsa_resp_t want);
		hsa_resp_t pred;
		int        idx [$];
		while (!steady && $urandom_range(0, 99) < 35) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= IN_TDATA_W'({slot, val, op});
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pred = table_step(op, val, slot);
		want_q.push_back(fixed ? want : pred);
		case (op)
			OP_ALLOC:   n_alloc++;
			OP_RELEASE: n_rel++;
			OP_LOOKUP:  n_look++;
			default: ;
		endcase
		if (pred.status == ST_FULL)     n_full++;
		if (pred.status == ST_OVERFLOW) n_ovf++;
		if (op == OP_ALLOC && pred.status == ST_OK)
			held_q.push_back(pred.slot);
		if (op == OP_RELEASE && pred.status == ST_OK) begin
			idx = held_q.find_first_index(x) with (x == slot);
			if (idx.size() > 0)
				held_q.delete(idx[0]);
		end
	endtask

	// response checker and receiver stalls
	always @(posedge clk) begin
		hsa_resp_t got;
		hsa_resp_t exp_r;
		if (m_tvalid && m_tready) begin
			got.slot   = m_tdata[SLOT_W-1:0];
			got.value  = m_tdata[SLOT_W +: VALUE_W];
			got.status = m_tdata[SLOT_W + VALUE_W +: STATUS_W];
			checked++;
			if (want_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected word slot=%0d value=%h status=%0d",
				         $realtime, got.slot, got.value, got.status);
			end else begin
				exp_r = want_q.pop_front();
				if (got.slot !== exp_r.slot) begin
					errors++;
					$display("%0t: slot_out expected %0d got %0d",
					         $realtime, exp_r.slot, got.slot);
				end
				if (got.value !== exp_r.value) begin
					errors++;
					$display("%0t: value_out expected %h got %h",
					         $realtime, exp_r.value, got.value);
				end
				if (got.status !== exp_r.status) begin
					errors++;
					$display("%0t: status expected %0d got %0d",
					         $realtime, exp_r.status, got.status);
				end
			end
		end
		m_tready <= steady || ($urandom_range(0, 99) >= 35);
	end

	initial begin
		int unsigned       alloc_pct;
		int unsigned       r;
		op_t               op;
		logic [VALUE_W-1:0] val;
		logic [SLOT_W-1:0] slot;
		table_reset();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i])
			send_word(dir_rows[i].op, dir_rows[i].value, dir_rows[i].slot,
			          dir_rows[i].fixed, dir_rows[i].want);

		alloc_pct = 50;
		for (int n = 0; n < 500; n++) begin
			steady = (n >= 200 && n < 300);
			// swing between filling and draining so both full and all-free are hit
			if (n % 20 == 0) begin
				case ($urandom_range(0, 2))
					0:       alloc_pct = 85;
					1:       alloc_pct = 50;
					default: alloc_pct = 15;
				endcase
			end
			r = $urandom_range(0, 99);
			case ($urandom_range(0, 3))
				0:       val = $urandom_range(0, 31);
				1:       val = $urandom_range(0, 1) ? '1 : '0;
				default: val = $urandom;
			endcase
			slot = SLOT_W'($urandom_range(0, 15));
			if (r < 4) begin
				op = OP_NONE;
			end else if (r < 16) begin
				op = OP_LOOKUP;
			end else if ($urandom_range(0, 99) < alloc_pct) begin
				op = OP_ALLOC;
			end else begin
				op = OP_RELEASE;
				if (held_q.size() > 0 && $urandom_range(0, 9) != 0)
					slot = held_q[$urandom_range(0, held_q.size() - 1)];
			end
			send_word(op, val, slot, 1'b0, NO_WANT);
		end
		steady = 1'b0;
		s_tvalid <= 1'b0;

		while (want_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("Checked %0d words: %0d allocate, %0d release, %0d lookup requests,",
		         checked, n_alloc, n_rel, n_look);
		$display("with %0d allocates on a full table and %0d releases on an empty one.",
		         n_full, n_ovf);
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin
		#1ms;
		$display("Timeout with %0d words outstanding", want_q.size());
		$display("*** FAILED ***");
		$finish;
	end

endmodule

### files.f
hw/rtl/hsa_pkg.sv
hw/rtl/hsa_slot_ram.sv
hw/rtl/handle_slot_allocator.sv
tb/handle_slot_allocator_tb.sv
